// ===== src/mcfd_pkg.sv =====
package mcfd_pkg;

    typedef logic [7:0]  t_code;
    typedef logic [15:0] t_duty;

    // command byte values
    localparam t_code CMD_PINS      = 8'h01;
    localparam t_code CMD_SPEED     = 8'h02;
    localparam t_code CMD_PRESET    = 8'h03;
    localparam t_code CMD_PWR_CYCLE = 8'h04;
    localparam t_code CMD_HEARTBEAT = 8'hBB;

    // H-bridge motor codes
    localparam t_code HB_STOP = 8'd0;
    localparam t_code HB_UP   = 8'd1;
    localparam t_code HB_DOWN = 8'd2;

    // wheel codes; speed step reuses ahead/back as up/down
    localparam t_code WH_BRAKE = 8'd0;
    localparam t_code WH_AHEAD = 8'd1;
    localparam t_code WH_BACK  = 8'd2;

    // preset select
    localparam t_code SEL_STRAIGHT = 8'd1;
    localparam t_code SEL_LEFT     = 8'd2;
    localparam t_code SEL_RIGHT    = 8'd3;

    // configuration register indexes
    localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [1:0] REG_DUTY_CEILING = 2'd1;
    localparam logic [1:0] REG_DUTY_FLOOR   = 2'd2;

    localparam t_duty RST_STEP_SIZE    = 16'd50;
    localparam t_duty RST_DUTY_CEILING = 16'd500;
    localparam t_duty RST_DUTY_FLOOR   = 16'd100;
    localparam t_duty RST_DUTY         = 16'd80;
    localparam t_duty RST_PRESET       = 16'd400;

endpackage

// ===== src/motor_command_frame_decoder.sv =====
// Result path: the input register, then one update stage that writes the
// pin/duty state and the result flags.
// Throughput: 1 frame per cycle while the output is not stalled; the single state update stage sets this.
// Reset: synchronous, active low; pins, duties, presets and config registers
// return to their power-up values, no result pending.
module motor_command_frame_decoder
    import mcfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_command,
    input  logic [7:0]  i_hbridge_one_code,
    input  logic [7:0]  i_hbridge_two_code,
    input  logic [7:0]  i_hbridge_three_code,
    input  logic [7:0]  i_hbridge_four_code,
    input  logic [7:0]  i_left_front_code,
    input  logic [7:0]  i_left_rear_code,
    input  logic [7:0]  i_right_front_code,
    input  logic [7:0]  i_right_rear_code,
    input  logic [7:0]  i_preset_select,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_hbridge_pins,
    output logic [3:0]  o_brake_pins,
    output logic [3:0]  o_direction_pins,
    output logic [3:0]  o_enable_pins,
    output logic        o_power_on,
    output logic [15:0] o_duty_left_front,
    output logic [15:0] o_duty_left_rear,
    output logic [15:0] o_duty_right_front,
    output logic [15:0] o_duty_right_rear,
    output logic        o_heartbeat_reply,
    output logic        o_power_cycle
);

    // config registers
    t_duty r_step_size, r_duty_ceiling, r_duty_floor;

    // input register
    logic  r_in_valid;
    t_code r_command;
    t_code r_hb_code [4];
    t_code r_wh_code [4];
    t_code r_preset_sel;

    // state; doubles as the result register since it only changes on a result load
    logic [7:0] r_bridge, n_bridge;
    logic [3:0] r_brake, n_brake;
    logic [3:0] r_dir, n_dir;
    logic [3:0] r_enable, n_enable;
    logic       r_power, n_power;
    t_duty      r_duty [4];
    t_duty      n_duty [4];
    t_duty      r_preset [3];
    t_duty      n_preset [3];
    logic       r_out_valid;
    logic       r_heartbeat, n_heartbeat;
    logic       r_cycled, n_cycled;

    logic  advance;
    logic  in_take;
    t_duty duty_inc [4];
    t_duty duty_dec [4];
    t_duty preset_val;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size    <= RST_STEP_SIZE;
            r_duty_ceiling <= RST_DUTY_CEILING;
            r_duty_floor   <= RST_DUTY_FLOOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                REG_DUTY_CEILING: r_duty_ceiling <= i_cfg_data;
                REG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command    <= i_command;
            r_hb_code[0] <= i_hbridge_one_code;
            r_hb_code[1] <= i_hbridge_two_code;
            r_hb_code[2] <= i_hbridge_three_code;
            r_hb_code[3] <= i_hbridge_four_code;
            r_wh_code[0] <= i_left_front_code;
            r_wh_code[1] <= i_left_rear_code;
            r_wh_code[2] <= i_right_front_code;
            r_wh_code[3] <= i_right_rear_code;
            r_preset_sel <= i_preset_select;
        end
    end

    // 16-bit wrap, then clamp
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            duty_inc[k] = r_duty[k] + r_step_size;
            duty_dec[k] = r_duty[k] - r_step_size;
            if (duty_inc[k] >= r_duty_ceiling) duty_inc[k] = r_duty_ceiling;
            if (duty_dec[k] <= r_duty_floor)   duty_dec[k] = r_duty_floor;
        end
    end

    assign preset_val = {r_hb_code[1], r_hb_code[0]};

    always_comb begin
        n_bridge    = r_bridge;
        n_brake     = r_brake;
        n_dir       = r_dir;
        n_enable    = r_enable;
        n_power     = r_power;
        n_duty      = r_duty;
        n_preset    = r_preset;
        n_heartbeat = 1'b0;
        n_cycled    = 1'b0;
        unique case (r_command)
            CMD_HEARTBEAT: n_heartbeat = 1'b1;
            CMD_PINS: begin
                for (int k = 0; k < 4; k++) begin
                    case (r_hb_code[k])
                        HB_STOP: n_bridge[2*k +: 2] = 2'b11;
                        HB_UP:   n_bridge[2*k +: 2] = 2'b01;
                        HB_DOWN: n_bridge[2*k +: 2] = 2'b10;
                        default: ;
                    endcase
                    case (r_wh_code[k])
                        WH_BRAKE: n_brake[k] = 1'b1;
                        WH_AHEAD: begin
                            n_brake[k]  = 1'b0;
                            n_dir[k]    = 1'b0;
                            n_enable[k] = 1'b0;
                        end
                        WH_BACK: begin
                            n_brake[k]  = 1'b0;
                            n_dir[k]    = 1'b1;
                            n_enable[k] = 1'b0;
                        end
                        default: ;
                    endcase
                end
                // left rear vs right front mismatch means straight; all ahead or all back is a turn
                if (r_wh_code[1] != r_wh_code[2]) begin
                    for (int k = 0; k < 4; k++) n_duty[k] = r_preset[0];
                end
                if (r_wh_code[0] == WH_AHEAD && r_wh_code[1] == WH_AHEAD &&
                    r_wh_code[2] == WH_AHEAD && r_wh_code[3] == WH_AHEAD) begin
                    n_duty[0] = r_preset[1];
                    n_duty[1] = r_preset[1];
                    n_duty[2] = r_preset[2];
                    n_duty[3] = r_preset[2];
                end
                if (r_wh_code[0] == WH_BACK && r_wh_code[1] == WH_BACK &&
                    r_wh_code[2] == WH_BACK && r_wh_code[3] == WH_BACK) begin
                    n_duty[0] = r_preset[2];
                    n_duty[1] = r_preset[2];
                    n_duty[2] = r_preset[1];
                    n_duty[3] = r_preset[1];
                end
            end
            CMD_SPEED: begin
                for (int k = 0; k < 4; k++) begin
                    case (r_wh_code[k])
                        WH_AHEAD: n_duty[k] = duty_inc[k];
                        WH_BACK:  n_duty[k] = duty_dec[k];
                        default: ;
                    endcase
                end
            end
            CMD_PRESET: begin
                case (r_preset_sel)
                    SEL_STRAIGHT: begin
                        n_preset[0] = preset_val;
                        for (int k = 0; k < 4; k++) n_duty[k] = preset_val;
                    end
                    SEL_LEFT:  n_preset[1] = preset_val;
                    SEL_RIGHT: n_preset[2] = preset_val;
                    default: ;
                endcase
            end
            CMD_PWR_CYCLE: begin
                n_enable = 4'hF;
                n_power  = 1'b1;
                n_cycled = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bridge    <= 8'h00;
            r_brake     <= 4'hF;
            r_dir       <= 4'hF;
            r_enable    <= 4'hF;
            r_power     <= 1'b0;
            r_heartbeat <= 1'b0;
            r_cycled    <= 1'b0;
            for (int k = 0; k < 4; k++) r_duty[k] <= RST_DUTY;
            for (int k = 0; k < 3; k++) r_preset[k] <= RST_PRESET;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_bridge    <= n_bridge;
                r_brake     <= n_brake;
                r_dir       <= n_dir;
                r_enable    <= n_enable;
                r_power     <= n_power;
                r_heartbeat <= n_heartbeat;
                r_cycled    <= n_cycled;
                r_duty      <= n_duty;
                r_preset    <= n_preset;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hbridge_pins     = r_bridge;
    assign o_brake_pins       = r_brake;
    assign o_direction_pins   = r_dir;
    assign o_enable_pins      = r_enable;
    assign o_power_on         = r_power;
    assign o_duty_left_front  = r_duty[0];
    assign o_duty_left_rear   = r_duty[1];
    assign o_duty_right_front = r_duty[2];
    assign o_duty_right_rear  = r_duty[3];
    assign o_heartbeat_reply  = r_heartbeat;
    assign o_power_cycle      = r_cycled;

`ifndef SYNTHESIS
    a_cycle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_power_cycle |-> o_power_on && o_enable_pins == 4'hF)
        else $error("power cycle result without power on and drivers disabled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_heartbeat_reply && o_power_cycle))
        else $error("heartbeat and power cycle flags both set");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_command))
        else $error("held frame lost from input register");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_bridge) && $stable(r_preset[0]) && $stable(r_duty[0]))
        else $error("state changed without a frame update");
`endif

endmodule
